// ===== rtl/lhist_pkg.sv =====
// lhist_pkg: shared types and constants of the block i/o latency histogram
// holds the command, result and table entry layouts and the status and state codes
// no dependencies
package lhist_pkg;

    // op letters of a request
    localparam logic [7:0] LETTER_R = 8'h52;
    localparam logic [7:0] LETTER_W = 8'h57;
    localparam logic [7:0] LETTER_D = 8'h44;
    localparam logic [7:0] LETTER_F = 8'h46;

    localparam int unsigned NS_PER_US = 1000;
    // recency stamp, one tick per table touch
    localparam int unsigned STAMP_W = 48;
    // bin threshold register, holds NS_PER_US shifted up to 64 places
    localparam int unsigned THR_W = 75;

    typedef enum logic [1:0] {
        OPN_ISSUE    = 2'd0,
        OPN_COMPLETE = 2'd1,
        OPN_READ     = 2'd2,
        OPN_NONE     = 2'd3
    } operation_t;

    typedef enum logic [1:0] {
        KIND_ISSUE,
        KIND_COMPLETE,
        KIND_READ,
        KIND_IGNORE
    } kind_t;

    typedef enum logic [2:0] {
        STAT_DONE       = 3'd0,
        STAT_UNKNOWN_OP = 3'd1,
        STAT_NO_START   = 3'd2,
        STAT_NEG_DELTA  = 3'd3,
        STAT_READ_MISS  = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PSCAN,
        ST_PDONE,
        ST_BIN,
        ST_HSCAN,
        ST_HDONE,
        ST_CREAD,
        ST_ZERO,
        ST_EMIT
    } state_t;

    typedef struct packed {
        kind_t       kind;
        logic        known;
        logic [1:0]  opc;
        logic [31:0] device;
        logic [63:0] sector;
        logic [63:0] time_ns;
        logic [4:0]  read_bin;
    } cmd_t;

    typedef struct packed {
        status_t     status;
        logic [4:0]  bin_used;
        logic [31:0] bin_count;
    } res_t;

    typedef struct packed {
        logic               valid;
        logic [STAMP_W-1:0] stamp;
        logic [31:0]        device;
        logic [63:0]        sector;
        logic [63:0]        time_ns;
    } pend_entry_t;

    typedef struct packed {
        logic [33:0]        key;
        logic [STAMP_W-1:0] stamp;
    } hist_entry_t;

endpackage

// ===== rtl/lhist_fifo.sv =====
// lhist_fifo: two-entry queue of any packed type
// used between front and back and on the result side; no package use
module lhist_fifo #(
    parameter type T = logic
) (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  T     din,
    output logic full,
    input  logic pop,
    output T     dout,
    output logic empty
);

    T           mem_reg [2];
    logic       wptr_reg;
    logic       rptr_reg;
    logic [1:0] cnt_reg;
    logic       do_push;
    logic       do_pop;

    assign full    = (cnt_reg == 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
                wptr_reg <= !wptr_reg;
            if (do_pop)
                rptr_reg <= !rptr_reg;
            if (do_push && !do_pop)
                cnt_reg <= cnt_reg + 2'd1;
            else if (do_pop && !do_push)
                cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wptr_reg] <= din;
    end

endmodule

// ===== rtl/lhist_front.sv =====
// lhist_front: takes input transactions and classifies them into commands
// depends on lhist_pkg
module lhist_front (
    input  logic              push,
    output logic              full,
    input  logic [1:0]        operation,
    input  logic [31:0]       device,
    input  logic [63:0]       sector,
    input  logic [7:0]        op_letter,
    input  logic [63:0]       time_ns,
    input  logic [4:0]        read_bin,
    input  logic              hold,
    input  logic              q_full,
    output logic              q_push,
    output lhist_pkg::cmd_t   q_cmd
);

    logic       known;
    logic [1:0] opc;

    always_comb
    begin
        known = 1'b1;
        opc   = 2'd0;
        unique case (op_letter)
            lhist_pkg::LETTER_R: opc = 2'd0;
            lhist_pkg::LETTER_W: opc = 2'd1;
            lhist_pkg::LETTER_D: opc = 2'd2;
            lhist_pkg::LETTER_F: opc = 2'd3;
            default:             known = 1'b0;
        endcase
    end

    always_comb
    begin
        q_cmd.known    = known;
        q_cmd.opc      = opc;
        q_cmd.device   = device;
        q_cmd.sector   = sector;
        q_cmd.time_ns  = time_ns;
        q_cmd.read_bin = read_bin;
        // completions with an unknown letter still retire their pending entry
        unique case (lhist_pkg::operation_t'(operation))
            lhist_pkg::OPN_ISSUE:
                q_cmd.kind = known ? lhist_pkg::KIND_ISSUE : lhist_pkg::KIND_IGNORE;
            lhist_pkg::OPN_COMPLETE:
                q_cmd.kind = lhist_pkg::KIND_COMPLETE;
            lhist_pkg::OPN_READ:
                q_cmd.kind = known ? lhist_pkg::KIND_READ : lhist_pkg::KIND_IGNORE;
            default:
                q_cmd.kind = lhist_pkg::KIND_IGNORE;
        endcase
    end

    assign full   = q_full || hold;
    assign q_push = push && !full;

endmodule

// ===== rtl/lhist_back.sv =====
// lhist_back: sequencer that scans the pending and histogram tables and
// updates the counters; holds the three memories; depends on lhist_pkg
module lhist_back #(
    parameter int unsigned PENDING_ENTRIES   = 1024,
    parameter int unsigned HISTOGRAM_ENTRIES = 64,
    parameter int unsigned BINS              = 32
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cq_empty,
    input  lhist_pkg::cmd_t cq_data,
    output logic            cq_pop,
    input  logic            rq_full,
    output logic            rq_push,
    output lhist_pkg::res_t rq_data,
    output logic            clearing
);

    localparam int unsigned PW = (PENDING_ENTRIES > 1) ? $clog2(PENDING_ENTRIES) : 1;
    localparam int unsigned HW = (HISTOGRAM_ENTRIES > 1) ? $clog2(HISTOGRAM_ENTRIES) : 1;
    localparam int unsigned IW = (PW > HW) ? PW : HW;
    localparam int unsigned BW = $clog2(BINS);
    localparam int unsigned CD = HISTOGRAM_ENTRIES * BINS;
    localparam int unsigned CW = $clog2(CD);
    localparam int unsigned SW = lhist_pkg::STAMP_W;
    localparam int unsigned TW = lhist_pkg::THR_W;
    localparam logic [PW-1:0] LAST_P = PW'(PENDING_ENTRIES - 1);
    localparam logic [HW-1:0] LAST_H = HW'(HISTOGRAM_ENTRIES - 1);
    localparam logic [BW-1:0] LAST_B = BW'(BINS - 1);

    // memories
    lhist_pkg::pend_entry_t pend_mem [PENDING_ENTRIES];
    lhist_pkg::hist_entry_t hkey_mem [HISTOGRAM_ENTRIES];
    logic [31:0]            cnt_mem  [CD];

    lhist_pkg::pend_entry_t pm_rdata_reg;
    lhist_pkg::hist_entry_t hm_rdata_reg;
    logic [31:0]            cm_rdata_reg;
    logic [PW-1:0]          pm_raddr, pm_waddr;
    logic                   pm_we;
    lhist_pkg::pend_entry_t pm_wdata;
    logic [HW-1:0]          hm_raddr, hm_waddr;
    logic                   hm_we;
    lhist_pkg::hist_entry_t hm_wdata;
    logic [CW-1:0]          cm_raddr, cm_waddr;
    logic                   cm_we;
    logic [31:0]            cm_wdata;

    // control and working registers
    lhist_pkg::state_t state_reg, state_next;
    logic [IW-1:0]     idx_reg, idx_next;
    logic              issuing_reg, issuing_next;
    logic              chk_vld_reg, chk_vld_next;
    logic [IW-1:0]     chk_idx_reg, chk_idx_next;
    logic              hit_reg, hit_next;
    logic [IW-1:0]     hit_idx_reg, hit_idx_next;
    logic [63:0]       hit_time_reg, hit_time_next;
    logic              free_reg, free_next;
    logic [IW-1:0]     free_idx_reg, free_idx_next;
    logic [IW-1:0]     old_idx_reg, old_idx_next;
    logic [SW-1:0]     old_stamp_reg, old_stamp_next;
    logic [SW-1:0]     stamp_reg, stamp_next;
    lhist_pkg::cmd_t   cmd_reg, cmd_next;
    logic [63:0]       diff_reg, diff_next;
    logic [TW-1:0]     thr_reg, thr_next;
    logic [BW-1:0]     bin_reg, bin_next;
    logic [BW-1:0]     zc_reg, zc_next;
    logic [HW-1:0]     slot_reg, slot_next;
    lhist_pkg::res_t   res_reg, res_next;
    logic [HISTOGRAM_ENTRIES-1:0] hvalid_reg, hvalid_next;

    logic [63:0]   diff_w;
    logic [IW-1:0] ptgt;
    logic [HW-1:0] htgt;
    logic          h_ent_valid;
    logic [33:0]   hkey;

    assign clearing = (state_reg == lhist_pkg::ST_CLEAR);
    assign rq_data  = res_reg;
    assign diff_w   = cmd_reg.time_ns - hit_time_reg;
    assign hkey     = {cmd_reg.device, cmd_reg.opc};
    assign h_ent_valid = hvalid_reg[chk_idx_reg[HW-1:0]];
    assign ptgt = hit_reg ? hit_idx_reg : (free_reg ? free_idx_reg : old_idx_reg);
    assign htgt = hit_reg ? hit_idx_reg[HW-1:0]
                : (free_reg ? free_idx_reg[HW-1:0] : old_idx_reg[HW-1:0]);

    always_ff @(posedge clk)
    begin
        pm_rdata_reg <= pend_mem[pm_raddr];
        if (pm_we)
            pend_mem[pm_waddr] <= pm_wdata;
    end

    always_ff @(posedge clk)
    begin
        hm_rdata_reg <= hkey_mem[hm_raddr];
        if (hm_we)
            hkey_mem[hm_waddr] <= hm_wdata;
    end

    always_ff @(posedge clk)
    begin
        cm_rdata_reg <= cnt_mem[cm_raddr];
        if (cm_we)
            cnt_mem[cm_waddr] <= cm_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= lhist_pkg::ST_CLEAR;
            idx_reg     <= '0;
            issuing_reg <= 1'b0;
            chk_vld_reg <= 1'b0;
            stamp_reg   <= '0;
            hvalid_reg  <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            issuing_reg <= issuing_next;
            chk_vld_reg <= chk_vld_next;
            stamp_reg   <= stamp_next;
            hvalid_reg  <= hvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chk_idx_reg   <= chk_idx_next;
        hit_reg       <= hit_next;
        hit_idx_reg   <= hit_idx_next;
        hit_time_reg  <= hit_time_next;
        free_reg      <= free_next;
        free_idx_reg  <= free_idx_next;
        old_idx_reg   <= old_idx_next;
        old_stamp_reg <= old_stamp_next;
        cmd_reg       <= cmd_next;
        diff_reg      <= diff_next;
        thr_reg       <= thr_next;
        bin_reg       <= bin_next;
        zc_reg        <= zc_next;
        slot_reg      <= slot_next;
        res_reg       <= res_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        issuing_next   = issuing_reg;
        chk_vld_next   = 1'b0;
        chk_idx_next   = chk_idx_reg;
        hit_next       = hit_reg;
        hit_idx_next   = hit_idx_reg;
        hit_time_next  = hit_time_reg;
        free_next      = free_reg;
        free_idx_next  = free_idx_reg;
        old_idx_next   = old_idx_reg;
        old_stamp_next = old_stamp_reg;
        stamp_next     = stamp_reg;
        cmd_next       = cmd_reg;
        diff_next      = diff_reg;
        thr_next       = thr_reg;
        bin_next       = bin_reg;
        zc_next        = zc_reg;
        slot_next      = slot_reg;
        res_next       = res_reg;
        hvalid_next    = hvalid_reg;
        cq_pop         = 1'b0;
        rq_push        = 1'b0;
        pm_raddr       = idx_reg[PW-1:0];
        pm_we          = 1'b0;
        pm_waddr       = idx_reg[PW-1:0];
        pm_wdata       = '0;
        hm_raddr       = idx_reg[HW-1:0];
        hm_we          = 1'b0;
        hm_waddr       = htgt;
        hm_wdata       = '0;
        cm_raddr       = '0;
        cm_we          = 1'b0;
        cm_waddr       = '0;
        cm_wdata       = '0;

        unique case (state_reg)
            lhist_pkg::ST_CLEAR:
            begin
                // invalidate every pending slot, one a cycle
                pm_we    = 1'b1;
                idx_next = idx_reg + IW'(1);
                if (idx_reg[PW-1:0] == LAST_P)
                    state_next = lhist_pkg::ST_IDLE;
            end

            lhist_pkg::ST_IDLE:
            begin
                if (!cq_empty)
                begin
                    cq_pop         = 1'b1;
                    cmd_next       = cq_data;
                    idx_next       = '0;
                    issuing_next   = 1'b1;
                    hit_next       = 1'b0;
                    free_next      = 1'b0;
                    old_idx_next   = '0;
                    old_stamp_next = '1;
                    res_next       = '{status: lhist_pkg::STAT_DONE, bin_used: '0,
                                       bin_count: '0};
                    unique case (cq_data.kind)
                        lhist_pkg::KIND_ISSUE,
                        lhist_pkg::KIND_COMPLETE: state_next = lhist_pkg::ST_PSCAN;
                        lhist_pkg::KIND_READ:     state_next = lhist_pkg::ST_HSCAN;
                        default:
                        begin
                            res_next.status = lhist_pkg::STAT_UNKNOWN_OP;
                            state_next      = lhist_pkg::ST_EMIT;
                        end
                    endcase
                end
            end

            lhist_pkg::ST_PSCAN:
            begin
                if (issuing_reg)
                begin
                    idx_next     = idx_reg + IW'(1);
                    issuing_next = (idx_reg[PW-1:0] != LAST_P);
                    chk_vld_next = 1'b1;
                    chk_idx_next = idx_reg;
                end
                if (chk_vld_reg)
                begin
                    if (pm_rdata_reg.valid && pm_rdata_reg.device == cmd_reg.device
                        && pm_rdata_reg.sector == cmd_reg.sector)
                    begin
                        hit_next      = 1'b1;
                        hit_idx_next  = chk_idx_reg;
                        hit_time_next = pm_rdata_reg.time_ns;
                    end
                    if (!pm_rdata_reg.valid && !free_reg)
                    begin
                        free_next     = 1'b1;
                        free_idx_next = chk_idx_reg;
                    end
                    if (pm_rdata_reg.valid && pm_rdata_reg.stamp < old_stamp_reg)
                    begin
                        old_idx_next   = chk_idx_reg;
                        old_stamp_next = pm_rdata_reg.stamp;
                    end
                    if (chk_idx_reg[PW-1:0] == LAST_P)
                        state_next = lhist_pkg::ST_PDONE;
                end
            end

            lhist_pkg::ST_PDONE:
            begin
                state_next = lhist_pkg::ST_EMIT;
                if (cmd_reg.kind == lhist_pkg::KIND_ISSUE)
                begin
                    // hit, else first free slot, else least recent
                    pm_we      = 1'b1;
                    pm_waddr   = ptgt[PW-1:0];
                    pm_wdata   = '{valid: 1'b1, stamp: stamp_reg, device: cmd_reg.device,
                                   sector: cmd_reg.sector, time_ns: cmd_reg.time_ns};
                    stamp_next = stamp_reg + SW'(1);
                end
                else if (!hit_reg)
                begin
                    res_next.status = lhist_pkg::STAT_NO_START;
                end
                else
                begin
                    pm_we     = 1'b1;
                    pm_waddr  = hit_idx_reg[PW-1:0];
                    diff_next = diff_w;
                    if (diff_w[63])
                        res_next.status = lhist_pkg::STAT_NEG_DELTA;
                    else if (!cmd_reg.known)
                        res_next.status = lhist_pkg::STAT_UNKNOWN_OP;
                    else
                    begin
                        thr_next   = TW'(2 * lhist_pkg::NS_PER_US);
                        bin_next   = '0;
                        state_next = lhist_pkg::ST_BIN;
                    end
                end
            end

            lhist_pkg::ST_BIN:
            begin
                // one threshold of 1000 << (bin + 1) a cycle
                if (bin_reg != LAST_B && TW'(diff_reg) >= thr_reg)
                begin
                    bin_next = bin_reg + BW'(1);
                    thr_next = thr_reg << 1;
                end
                else
                begin
                    idx_next       = '0;
                    issuing_next   = 1'b1;
                    hit_next       = 1'b0;
                    free_next      = 1'b0;
                    old_idx_next   = '0;
                    old_stamp_next = '1;
                    state_next     = lhist_pkg::ST_HSCAN;
                end
            end

            lhist_pkg::ST_HSCAN:
            begin
                if (issuing_reg)
                begin
                    idx_next     = idx_reg + IW'(1);
                    issuing_next = (idx_reg[HW-1:0] != LAST_H);
                    chk_vld_next = 1'b1;
                    chk_idx_next = idx_reg;
                end
                if (chk_vld_reg)
                begin
                    if (h_ent_valid && hm_rdata_reg.key == hkey)
                    begin
                        hit_next     = 1'b1;
                        hit_idx_next = chk_idx_reg;
                    end
                    if (!h_ent_valid && !free_reg)
                    begin
                        free_next     = 1'b1;
                        free_idx_next = chk_idx_reg;
                    end
                    if (h_ent_valid && hm_rdata_reg.stamp < old_stamp_reg)
                    begin
                        old_idx_next   = chk_idx_reg;
                        old_stamp_next = hm_rdata_reg.stamp;
                    end
                    if (chk_idx_reg[HW-1:0] == LAST_H)
                        state_next = lhist_pkg::ST_HDONE;
                end
            end

            lhist_pkg::ST_HDONE:
            begin
                if (cmd_reg.kind == lhist_pkg::KIND_READ)
                begin
                    if (!hit_reg || 7'(cmd_reg.read_bin) >= 7'(BINS))
                    begin
                        res_next.status = lhist_pkg::STAT_READ_MISS;
                        state_next      = lhist_pkg::ST_EMIT;
                    end
                    else
                    begin
                        cm_raddr   = CW'(CW'(hit_idx_reg[HW-1:0]) * CW'(BINS)
                                     + CW'(BW'(cmd_reg.read_bin)));
                        state_next = lhist_pkg::ST_CREAD;
                    end
                end
                else
                begin
                    hm_we      = 1'b1;
                    hm_wdata   = '{key: hkey, stamp: stamp_reg};
                    stamp_next = stamp_reg + SW'(1);
                    slot_next  = htgt;
                    if (hit_reg)
                    begin
                        cm_raddr   = CW'(CW'(htgt) * CW'(BINS) + CW'(bin_reg));
                        state_next = lhist_pkg::ST_CREAD;
                    end
                    else
                    begin
                        // fresh histogram: counters are cleared before use
                        hvalid_next[htgt] = 1'b1;
                        zc_next           = '0;
                        state_next        = lhist_pkg::ST_ZERO;
                    end
                end
            end

            lhist_pkg::ST_CREAD:
            begin
                state_next = lhist_pkg::ST_EMIT;
                if (cmd_reg.kind == lhist_pkg::KIND_READ)
                    res_next.bin_count = cm_rdata_reg;
                else
                begin
                    cm_we             = 1'b1;
                    cm_waddr          = CW'(CW'(slot_reg) * CW'(BINS) + CW'(bin_reg));
                    cm_wdata          = cm_rdata_reg + 32'd1;
                    res_next.bin_used = 5'(bin_reg);
                end
            end

            lhist_pkg::ST_ZERO:
            begin
                cm_we    = 1'b1;
                cm_waddr = CW'(CW'(slot_reg) * CW'(BINS) + CW'(zc_reg));
                cm_wdata = (zc_reg == bin_reg) ? 32'd1 : 32'd0;
                zc_next  = zc_reg + BW'(1);
                if (zc_reg == LAST_B)
                begin
                    res_next.bin_used = 5'(bin_reg);
                    state_next        = lhist_pkg::ST_EMIT;
                end
            end

            lhist_pkg::ST_EMIT:
            begin
                if (!rq_full)
                begin
                    rq_push    = 1'b1;
                    state_next = lhist_pkg::ST_IDLE;
                end
            end

            default:
                state_next = lhist_pkg::ST_IDLE;
        endcase
    end

endmodule

// ===== rtl/block_io_latency_histogram.sv =====
// block_io_latency_histogram: top level of the block i/o latency histogram
// ties the classifying front, the command and result queues and the sequencer
// depends on lhist_pkg, lhist_front, lhist_fifo and lhist_back
//
// Measures block request latency as a log2 histogram per (device, op).
// An issue transaction stores its time under (device, sector) in a pending
// table kept in least-recently-used order; a completion finds and retires it,
// turns the nanosecond delta into a microsecond bin and counts it, and a read
// transaction returns one bin. Exactly one result comes back per transaction,
// in order. Both sides behave as queues: two commands can wait ahead of the
// sequencer and two results can wait for pop. Table lookups are linear sweeps
// of synchronous memories, one entry a cycle, which sets the cost: an issue
// sweeps the pending table, a read the histogram directory; a completion that
// is counted sweeps both, with the bin search between them, and clears the
// BINS counters of a newly allocated histogram one a cycle. Ignored
// transactions go straight to the result queue. After reset a clearing pass
// over every pending entry empties the pending table; full stays high until
// it ends.
module block_io_latency_histogram #(
    parameter int unsigned PENDING_ENTRIES   = 1024,
    parameter int unsigned HISTOGRAM_ENTRIES = 64,
    parameter int unsigned BINS              = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    // input queue side
    input  logic        push,
    output logic        full,
    input  logic [1:0]  operation,
    input  logic [31:0] device,
    input  logic [63:0] sector,
    input  logic [7:0]  op_letter,
    input  logic [63:0] time_ns,
    input  logic [4:0]  read_bin,
    // result queue side
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  status,
    output logic [4:0]  bin_used,
    output logic [31:0] bin_count
);

    lhist_pkg::cmd_t fq_cmd;
    lhist_pkg::cmd_t cq_data;
    lhist_pkg::res_t rq_din;
    lhist_pkg::res_t rq_dout;
    logic            fq_push;
    logic            cq_full;
    logic            cq_empty;
    logic            cq_pop;
    logic            rq_push;
    logic            rq_full;
    logic            clearing;

    // decode the op letter and sort each transaction into a command
    lhist_front u_front (
        .push      (push),
        .full      (full),
        .operation (operation),
        .device    (device),
        .sector    (sector),
        .op_letter (op_letter),
        .time_ns   (time_ns),
        .read_bin  (read_bin),
        .hold      (clearing),
        .q_full    (cq_full),
        .q_push    (fq_push),
        .q_cmd     (fq_cmd)
    );

    // short command queue decouples acceptance from the sweeps
    lhist_fifo #(.T(lhist_pkg::cmd_t)) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (fq_push),
        .din   (fq_cmd),
        .full  (cq_full),
        .pop   (cq_pop),
        .dout  (cq_data),
        .empty (cq_empty)
    );

    // table sweeps, bin search and counter update
    lhist_back #(
        .PENDING_ENTRIES   (PENDING_ENTRIES),
        .HISTOGRAM_ENTRIES (HISTOGRAM_ENTRIES),
        .BINS              (BINS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cq_empty (cq_empty),
        .cq_data  (cq_data),
        .cq_pop   (cq_pop),
        .rq_full  (rq_full),
        .rq_push  (rq_push),
        .rq_data  (rq_din),
        .clearing (clearing)
    );

    // results wait here so a slow consumer only stalls the sequencer
    lhist_fifo #(.T(lhist_pkg::res_t)) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (rq_push),
        .din   (rq_din),
        .full  (rq_full),
        .pop   (pop),
        .dout  (rq_dout),
        .empty (empty)
    );

    assign status    = rq_dout.status;
    assign bin_used  = rq_dout.bin_used;
    assign bin_count = rq_dout.bin_count;

endmodule

// ===== rtl/lhist_checker.sv =====
// lhist_checker: port-level assertions for block_io_latency_histogram
// bound to the top level below; depends on lhist_pkg
module lhist_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        empty,
    input logic        pop,
    input logic [2:0]  status,
    input logic [4:0]  bin_used,
    input logic [31:0] bin_count
);

    // status code stays within the defined set
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (status <= 3'(lhist_pkg::STAT_READ_MISS)))
        else $error("status code out of range");

    // a nonzero bin is reported only by a successful completion
    a_bin_used_done: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && bin_used != 5'd0) |-> (status == 3'(lhist_pkg::STAT_DONE)))
        else $error("bin reported with failure status");

    // a nonzero count is reported only by a successful read, which uses no bin
    a_count_read: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && bin_count != 32'd0)
        |-> (status == 3'(lhist_pkg::STAT_DONE) && bin_used == 5'd0))
        else $error("count reported outside a successful read");

    // a waiting result holds until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(status) && $stable(bin_used)
                              && $stable(bin_count)))
        else $error("waiting result changed");

endmodule

bind block_io_latency_histogram lhist_checker u_lhist_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .empty     (empty),
    .pop       (pop),
    .status    (status),
    .bin_used  (bin_used),
    .bin_count (bin_count)
);

// ===== tb/testbench.sv =====
// testbench: self-checking bench for the block i/o latency histogram
// queue-driven sender, random-stall receiver and an in-bench latency histogram predictor
// depends on lhist_pkg and block_io_latency_histogram
module testbench;

    localparam int PEND_N = 1024;
    localparam int HIST_N = 64;
    localparam int NBINS = 32;
    localparam int RANDOM_ITEMS = 1200;
    // overall watchdog; allow several times the whole run
    localparam longint CYCLE_LIMIT = 8000000;
    localparam int STALL_AT = 150;
    localparam int STALL_CYCLES = 20000;
    localparam int SYNC_AT = 700;

    typedef struct {
        logic [1:0]  opn;
        logic [31:0] dev;
        logic [63:0] sec;
        logic [7:0]  ltr;
        logic [63:0] tns;
        logic [4:0]  rbin;
    } request_t;

    typedef struct {
        lhist_pkg::status_t st;
        logic [4:0]         bin;
        logic [31:0]        cnt;
    } outcome_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        pop = 1'b0;
    logic [1:0]  operation = '0;
    logic [31:0] device = '0;
    logic [63:0] sector = '0;
    logic [7:0]  op_letter = '0;
    logic [63:0] time_ns = '0;
    logic [4:0]  read_bin = '0;
    logic        full;
    logic        empty;
    logic [2:0]  status;
    logic [4:0]  bin_used;
    logic [31:0] bin_count;

    block_io_latency_histogram #(
        .PENDING_ENTRIES(PEND_N),
        .HISTOGRAM_ENTRIES(HIST_N),
        .BINS(NBINS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .operation(operation),
        .device(device),
        .sector(sector),
        .op_letter(op_letter),
        .time_ns(time_ns),
        .read_bin(read_bin),
        .empty(empty),
        .pop(pop),
        .status(status),
        .bin_used(bin_used),
        .bin_count(bin_count)
    );

    // ---------------------------------------------------------------
    // predictor state: table 0 is the pending table, table 1 the
    // histogram directory; both kept in lru rank order (0 = newest)
    // ---------------------------------------------------------------
    bit          tvld  [2][PEND_N];
    int unsigned trank [2][PEND_N];
    logic [31:0] pend_dev  [PEND_N];
    logic [63:0] pend_sec  [PEND_N];
    logic [63:0] pend_time [PEND_N];
    logic [33:0] hist_key  [HIST_N];
    logic [31:0] hist_cnt  [HIST_N][NBINS];

    request_t stim_q[$];
    outcome_t outcome_q[$];
    request_t cur;

    int     mismatches = 0;
    int     n_accepted = 0;
    longint cycles = 0;
    logic   took_in = 1'b0;
    logic   took_out = 1'b0;
    int     tx_gap = 0;
    int     rx_gap = 0;
    int     stall_left = 0;
    bit     stall_started = 0;
    bit     synced = 0;

    // ---------------- lru helpers ----------------
    function automatic void lru_touch(int t, int n, int i, bit fresh);
        for (int j = 0; j < n; j++)
            if (j != i && tvld[t][j] && (fresh || trank[t][j] < trank[t][i]))
                trank[t][j]++;
        trank[t][i] = 0;
        tvld[t][i] = 1;
    endfunction

    function automatic void lru_remove(int t, int n, int i);
        for (int j = 0; j < n; j++)
            if (j != i && tvld[t][j] && trank[t][j] > trank[t][i])
                trank[t][j]--;
        tvld[t][i] = 0;
        trank[t][i] = 0;
    endfunction

    // first free slot, else the oldest entry
    function automatic int lru_victim(int t, int n);
        int best;
        best = 0;
        for (int j = 0; j < n; j++)
            if (!tvld[t][j])
                return j;
        for (int j = 1; j < n; j++)
            if (trank[t][j] > trank[t][best])
                best = j;
        return best;
    endfunction

    function automatic int letter_code(logic [7:0] l);
        case (l)
            lhist_pkg::LETTER_R: return 0;
            lhist_pkg::LETTER_W: return 1;
            lhist_pkg::LETTER_D: return 2;
            lhist_pkg::LETTER_F: return 3;
            default:             return -1;
        endcase
    endfunction

    function automatic int pend_find(logic [31:0] d, logic [63:0] s);
        for (int j = 0; j < PEND_N; j++)
            if (tvld[0][j] && pend_dev[j] == d && pend_sec[j] == s)
                return j;
        return -1;
    endfunction

    function automatic int hist_find(logic [33:0] k);
        for (int j = 0; j < HIST_N; j++)
            if (tvld[1][j] && hist_key[j] == k)
                return j;
        return -1;
    endfunction

    // expected result of one accepted transaction, updating the shadow tables
    function automatic outcome_t latency_outcome(request_t r);
        outcome_t    o;
        int          oc, i, h, b;
        logic [63:0] diff, us;
        logic [33:0] key;
        o.st = lhist_pkg::STAT_DONE;
        o.bin = '0;
        o.cnt = '0;
        oc = letter_code(r.ltr);
        case (r.opn)
            lhist_pkg::OPN_ISSUE:
            begin
                if (oc < 0)
                    o.st = lhist_pkg::STAT_UNKNOWN_OP;
                else
                begin
                    i = pend_find(r.dev, r.sec);
                    if (i >= 0)
                        lru_touch(0, PEND_N, i, 0);
                    else
                    begin
                        i = lru_victim(0, PEND_N);
                        if (tvld[0][i])
                            lru_remove(0, PEND_N, i);
                        pend_dev[i] = r.dev;
                        pend_sec[i] = r.sec;
                        lru_touch(0, PEND_N, i, 1);
                    end
                    pend_time[i] = r.tns;
                end
            end
            lhist_pkg::OPN_COMPLETE:
            begin
                i = pend_find(r.dev, r.sec);
                if (i < 0)
                    o.st = lhist_pkg::STAT_NO_START;
                else
                begin
                    diff = r.tns - pend_time[i];
                    lru_remove(0, PEND_N, i);
                    if (diff[63])
                        o.st = lhist_pkg::STAT_NEG_DELTA;
                    else if (oc < 0)
                        o.st = lhist_pkg::STAT_UNKNOWN_OP;
                    else
                    begin
                        us = diff / lhist_pkg::NS_PER_US;
                        if (us == 0)
                            us = 1;
                        b = 0;
                        while (us > 1)
                        begin
                            us = us >> 1;
                            b++;
                        end
                        if (b >= NBINS)
                            b = NBINS - 1;
                        key = {r.dev, 2'(oc)};
                        h = hist_find(key);
                        if (h >= 0)
                            lru_touch(1, HIST_N, h, 0);
                        else
                        begin
                            h = lru_victim(1, HIST_N);
                            if (tvld[1][h])
                                lru_remove(1, HIST_N, h);
                            hist_key[h] = key;
                            for (int k = 0; k < NBINS; k++)
                                hist_cnt[h][k] = '0;
                            lru_touch(1, HIST_N, h, 1);
                        end
                        hist_cnt[h][b] = hist_cnt[h][b] + 1;
                        o.bin = 5'(b);
                    end
                end
            end
            lhist_pkg::OPN_READ:
            begin
                if (oc < 0)
                    o.st = lhist_pkg::STAT_UNKNOWN_OP;
                else
                begin
                    h = hist_find({r.dev, 2'(oc)});
                    if (h < 0 || r.rbin >= NBINS)
                        o.st = lhist_pkg::STAT_READ_MISS;
                    else
                        o.cnt = hist_cnt[h][r.rbin];
                end
            end
            default: o.st = lhist_pkg::STAT_UNKNOWN_OP;
        endcase
        return o;
    endfunction

    task automatic add_item(logic [1:0] opn, logic [31:0] d, logic [63:0] s,
                            logic [7:0] l, logic [63:0] t, logic [4:0] rb);
        request_t r;
        r.opn = opn;
        r.dev = d;
        r.sec = s;
        r.ltr = l;
        r.tns = t;
        r.rbin = rb;
        stim_q.push_back(r);
    endtask

    function automatic logic [7:0] any_letter();
        case ($urandom_range(0, 3))
            0: return lhist_pkg::LETTER_R;
            1: return lhist_pkg::LETTER_W;
            2: return lhist_pkg::LETTER_D;
            default: return lhist_pkg::LETTER_F;
        endcase
    endfunction

    // mostly short gaps, some long; every third stretch of 150 runs flat out
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if ((n_accepted / 150) % 3 == 1)
            return 0;
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 4);
        return $urandom_range(20, 1500);
    endfunction

    // ---------------- clock and reset ----------------
    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // ---------------- stimulus ----------------
    initial
    begin
        request_t    open_q[$];
        request_t    done_q[$];
        request_t    r;
        logic [31:0] dev_pool[48];
        logic [63:0] delta;
        int          k, sel;

        // directed: extremes and the special cases
        add_item(lhist_pkg::OPN_READ, 32'h0, 64'h0, lhist_pkg::LETTER_R, 64'h0, 5'd0);
        add_item(lhist_pkg::OPN_ISSUE, '1, '1, lhist_pkg::LETTER_W, 64'h0, 5'd0);
        // zero us lands in bin 0
        add_item(lhist_pkg::OPN_COMPLETE, '1, '1, lhist_pkg::LETTER_W, 64'd999, 5'd0);
        add_item(lhist_pkg::OPN_READ, '1, 64'h0, lhist_pkg::LETTER_W, 64'h0, 5'd0);
        add_item(lhist_pkg::OPN_READ, '1, 64'h0, lhist_pkg::LETTER_W, 64'h0, 5'd31);
        // unknown op on issue
        add_item(lhist_pkg::OPN_ISSUE, 32'd3, 64'd3, 8'h00, 64'd0, 5'd0);
        add_item(lhist_pkg::OPN_ISSUE, 32'd0, 64'd0, lhist_pkg::LETTER_D, 64'd100, 5'd0);
        // same key overwritten
        add_item(lhist_pkg::OPN_ISSUE, 32'd0, 64'd0, lhist_pkg::LETTER_D, 64'd5000, 5'd0);
        // negative delta, then no start left
        add_item(lhist_pkg::OPN_COMPLETE, 32'd0, 64'd0, lhist_pkg::LETTER_D, 64'd4000, 5'd0);
        add_item(lhist_pkg::OPN_COMPLETE, 32'd0, 64'd0, lhist_pkg::LETTER_D, 64'd9000, 5'd0);
        add_item(lhist_pkg::OPN_ISSUE, 32'd1, 64'd5, lhist_pkg::LETTER_F, 64'd0, 5'd0);
        // capped at the last bin
        add_item(lhist_pkg::OPN_COMPLETE, 32'd1, 64'd5, lhist_pkg::LETTER_F,
                 64'h7fff_ffff_ffff_ffff, 5'd0);
        add_item(lhist_pkg::OPN_READ, 32'd1, 64'd0, lhist_pkg::LETTER_F, 64'd0, 5'd31);
        add_item(lhist_pkg::OPN_ISSUE, 32'd2, 64'd9, lhist_pkg::LETTER_R, 64'd10, 5'd0);
        // unknown op on completion
        add_item(lhist_pkg::OPN_COMPLETE, 32'd2, 64'd9, 8'hff, 64'd50000, 5'd0);
        add_item(lhist_pkg::OPN_COMPLETE, 32'd2, 64'd9, lhist_pkg::LETTER_R, 64'd60000, 5'd0);
        // read with an unknown letter
        add_item(lhist_pkg::OPN_READ, 32'd2, 64'd0, 8'h80, 64'd0, 5'd0);
        // operation code three
        add_item(lhist_pkg::OPN_NONE, '1, '1, '1, '1, '1);
        add_item(lhist_pkg::OPN_ISSUE, 32'd7, 64'd7, lhist_pkg::LETTER_R,
                 64'hffff_ffff_ffff_f000, 5'd0);
        // delta across wrap
        add_item(lhist_pkg::OPN_COMPLETE, 32'd7, 64'd7, lhist_pkg::LETTER_R, 64'h1000, 5'd0);
        add_item(lhist_pkg::OPN_READ, 32'd7, 64'd0, lhist_pkg::LETTER_R, 64'd0, 5'd3);

        dev_pool[0] = 32'h0;
        dev_pool[1] = '1;
        for (int j = 2; j < 48; j++)
            dev_pool[j] = $urandom;

        // random: mostly issue/complete pairs over a small pending set, so the
        // histogram directory sees far more keys than it holds
        k = 0;
        while (k < RANDOM_ITEMS)
        begin
            sel = $urandom_range(0, 99);
            if (open_q.size() > 40)
                sel = 50;
            if (sel < 38 || (open_q.size() == 0 && sel < 75))
            begin
                r.opn = lhist_pkg::OPN_ISSUE;
                if (open_q.size() > 0 && $urandom_range(0, 4) == 0)
                begin
                    r = open_q[$urandom_range(0, open_q.size() - 1)];
                    r.opn = lhist_pkg::OPN_ISSUE;
                end
                else
                begin
                    r.dev = dev_pool[$urandom_range(0, 47)];
                    r.sec = {$urandom, $urandom};
                end
                r.ltr = ($urandom_range(0, 9) == 0) ? 8'($urandom) : any_letter();
                r.tns = {$urandom, $urandom};
                r.rbin = 5'($urandom);
                if (letter_code(r.ltr) >= 0)
                    open_q.push_back(r);
            end
            else if (sel < 75)
            begin
                sel = $urandom_range(0, open_q.size() - 1);
                r = open_q[sel];
                open_q.delete(sel);
                r.opn = lhist_pkg::OPN_COMPLETE;
                delta = {$urandom, $urandom} >> $urandom_range(0, 63);
                delta[63] = 1'b0;
                if ($urandom_range(0, 19) == 0)
                    delta = -delta - 1;
                r.tns = r.tns + delta;
                r.ltr = ($urandom_range(0, 14) == 0) ? 8'($urandom) : any_letter();
                r.rbin = 5'($urandom);
                if (letter_code(r.ltr) >= 0)
                    done_q.push_back(r);
                if (done_q.size() > 30)
                    void'(done_q.pop_front());
            end
            else if (sel < 82)
            begin
                r.opn = lhist_pkg::OPN_COMPLETE;
                r.dev = dev_pool[$urandom_range(0, 47)];
                r.sec = {$urandom, $urandom};
                r.ltr = any_letter();
                r.tns = {$urandom, $urandom};
                r.rbin = 5'($urandom);
            end
            else if (sel < 98)
            begin
                if (done_q.size() > 0 && $urandom_range(0, 3) != 0)
                    r = done_q[$urandom_range(0, done_q.size() - 1)];
                else
                begin
                    r.dev = dev_pool[$urandom_range(0, 47)];
                    r.ltr = ($urandom_range(0, 9) == 0) ? 8'($urandom) : any_letter();
                end
                r.opn = lhist_pkg::OPN_READ;
                r.sec = {$urandom, $urandom};
                r.tns = {$urandom, $urandom};
                r.rbin = ($urandom_range(0, 2) == 0) ? 5'($urandom)
                                                      : 5'($urandom_range(0, 12));
            end
            else
            begin
                r.opn = lhist_pkg::OPN_NONE;
                r.dev = $urandom;
                r.sec = {$urandom, $urandom};
                r.ltr = 8'($urandom);
                r.tns = {$urandom, $urandom};
                r.rbin = 5'($urandom);
            end
            stim_q.push_back(r);
            k++;
        end

        // drain: everything sent, every result back, then a quiet spell
        @(posedge rst_n);
        while (!(stim_q.size() == 0 && !push && outcome_q.size() == 0))
            @(posedge clk);
        repeat (3000) @(posedge clk);
        if (mismatches == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

    // ---------------- long receiver hold-off ----------------
    always @(posedge clk)
    begin
        if (!stall_started && n_accepted >= STALL_AT)
        begin
            stall_started = 1;
            stall_left = STALL_CYCLES;
        end
        else if (stall_left > 0)
            stall_left--;
    end

    // ---------------- accept and predict, check results ----------------
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("testbench: FAIL");
            $finish;
        end

        if (rst_n && push && !full)
        begin
            outcome_q.push_back(latency_outcome(cur));
            n_accepted++;
            took_in <= 1'b1;
        end
        else
            took_in <= 1'b0;

        if (rst_n && pop && !empty)
        begin
            took_out <= 1'b1;
            if (outcome_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: status %0d bin %0d count %0d",
                             status, bin_used, bin_count);
            end
            else
            begin
                outcome_t e;
                e = outcome_q.pop_front();
                if (status !== e.st || bin_used !== e.bin || bin_count !== e.cnt)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: expected status %0d bin %0d count %0d,",
                                  " got %0d %0d %0d"},
                                 e.st, e.bin, e.cnt, status, bin_used, bin_count);
                end
            end
        end
        else
            took_out <= 1'b0;
    end

    // ---------------- sender ----------------
    always @(negedge clk)
    begin
        logic nxt;
        nxt = 1'b0;
        if (rst_n)
        begin
            if (push && !took_in)
                nxt = 1'b1;                 // transaction still on offer
            else if (tx_gap > 0)
                tx_gap--;
            else if (!synced && n_accepted >= SYNC_AT)
            begin
                // pause until every result is back
                if (outcome_q.size() == 0)
                    synced = 1;
            end
            else if (stim_q.size() > 0)
            begin
                cur = stim_q.pop_front();
                operation <= cur.opn;
                device <= cur.dev;
                sector <= cur.sec;
                op_letter <= cur.ltr;
                time_ns <= cur.tns;
                read_bin <= cur.rbin;
                nxt = 1'b1;
                tx_gap = pick_gap();
            end
        end
        push <= nxt;
    end

    // ---------------- receiver ----------------
    always @(negedge clk)
    begin
        if (took_out)
            rx_gap = pick_gap();
        if (!rst_n || stall_left > 0)
            pop <= 1'b0;
        else if (rx_gap > 0)
        begin
            rx_gap--;
            pop <= 1'b0;
        end
        else
            pop <= 1'b1;
    end

endmodule

// ===== files.f =====
rtl/lhist_pkg.sv
rtl/lhist_fifo.sv
rtl/lhist_front.sv
rtl/lhist_back.sv
rtl/block_io_latency_histogram.sv
rtl/lhist_checker.sv
tb/testbench.sv
